@@ rtl/olss_pkg.sv @@
`default_nettype none

package olss_pkg;

  // Field widths fixed by the item format
  localparam int SAMPLE_W = 10;
  localparam int LOAD_W   = 16;
  localparam int THRESH_W = 10;
  localparam int GAIN_W   = 8;
  localparam int SCALED_W = 12;
  localparam int DIFF_W   = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Divide by 100 as multiply by ceil(2^25 / 100) and shift; exact for products below 2^18
  localparam int SCALE_SHIFT = 25;
  localparam int SCALE_RECIP_W = 19;
  localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 19'd335545;
  localparam int GAIN_FACTOR_W = GAIN_W + SCALE_RECIP_W;
  localparam int SCALE_PROD_W  = SAMPLE_W + GAIN_FACTOR_W;

  // Register reset values
  localparam logic [THRESH_W-1:0] LEFT_LOW_RESET   = 10'd600;
  localparam logic [THRESH_W-1:0] LEFT_HIGH_RESET  = 10'd700;
  localparam logic [THRESH_W-1:0] RIGHT_LOW_RESET  = 10'd650;
  localparam logic [THRESH_W-1:0] RIGHT_HIGH_RESET = 10'd750;
  localparam logic [GAIN_W-1:0]   GAIN_RESET       = 8'd160;
  localparam logic [GAIN_FACTOR_W-1:0] GAIN_FACTOR_RESET =
    GAIN_FACTOR_W'(GAIN_RESET) * GAIN_FACTOR_W'(SCALE_RECIP);

  // Action codes
  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_LOAD   = 1'b1;

  // Round-robin slots
  typedef enum logic [1:0] {
    SLOT_LEFT_WHEEL  = 2'd0,
    SLOT_RIGHT_WHEEL = 2'd1,
    SLOT_LEFT_LINE   = 2'd2,
    SLOT_RIGHT_LINE  = 2'd3
  } slot_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_LOW   = 3'd0,
    REG_LEFT_HIGH  = 3'd1,
    REG_RIGHT_LOW  = 3'd2,
    REG_RIGHT_HIGH = 3'd3,
    REG_RIGHT_GAIN = 3'd4
  } cfg_reg_t;

  // Controls from the top level to one wheel counter
  typedef struct packed {
    logic step;
    logic load;
  } wheel_ctrl_t;

  // Controls from the top level to the line sensor unit
  typedef struct packed {
    logic step_left;
    logic step_right;
    logic gain_we;
  } line_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/olss_wheel.sv @@
`default_nettype none

module olss_wheel #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire olss_pkg::wheel_ctrl_t     ctrl,
  input  wire [olss_pkg::SAMPLE_W-1:0]   sample,
  input  wire [olss_pkg::THRESH_W-1:0]   low_threshold,
  input  wire [olss_pkg::THRESH_W-1:0]   high_threshold,
  input  wire [COUNT_WIDTH-1:0]          load_value,
  output logic                           edge_hit,
  output logic [COUNT_WIDTH-1:0]         count_next
);
  import olss_pkg::*;

  logic                   mark;
  logic                   mark_next;
  logic [COUNT_WIDTH-1:0] count;
  logic                   low_hit;
  logic                   high_hit;
  logic                   mark_mid;

  // Hysteresis: low test first, then high test on the updated mark
  always_comb begin
    low_hit  = ctrl.step && (sample < low_threshold) && mark;
    mark_mid = low_hit ? 1'b0 : mark;
    high_hit = ctrl.step && (sample > high_threshold) && !mark_mid;
    mark_next = high_hit ? 1'b1 : mark_mid;
    edge_hit  = low_hit || high_hit;
    if (ctrl.load) begin
      count_next = load_value;
    end else begin
      count_next = count + COUNT_WIDTH'({1'b0, low_hit} + {1'b0, high_hit});
    end
  end

  // Hold mark and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      mark  <= 1'b0;
      count <= '0;
    end else begin
      mark  <= mark_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/olss_line.sv @@
`default_nettype none

module olss_line (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire olss_pkg::line_ctrl_t           ctrl,
  input  wire [olss_pkg::SAMPLE_W-1:0]        sample,
  input  wire [olss_pkg::GAIN_W-1:0]          gain_data,
  output logic [olss_pkg::SAMPLE_W-1:0]       left_next,
  output logic [olss_pkg::SCALED_W-1:0]       right_next,
  output logic signed [olss_pkg::DIFF_W-1:0]  difference_next
);
  import olss_pkg::*;

  logic [SAMPLE_W-1:0]      left_store;
  logic [SCALED_W-1:0]      right_store;
  logic [GAIN_FACTOR_W-1:0] gain_factor;
  logic [SCALE_PROD_W-1:0]  scale_prod;

  // Scale right sample: sample * (gain * recip) >> shift gives floor(sample * gain / 100)
  always_comb begin
    scale_prod = SCALE_PROD_W'(sample) * SCALE_PROD_W'(gain_factor);
    left_next  = ctrl.step_left ? sample : left_store;
    right_next = ctrl.step_right ? scale_prod[SCALE_SHIFT +: SCALED_W] : right_store;
    difference_next = DIFF_W'(signed'({3'b000, left_next}) - signed'({1'b0, right_next}));
  end

  // Hold line stores; fold the reciprocal into the gain when it is written
  always_ff @(posedge clk) begin
    if (rst) begin
      left_store  <= '0;
      right_store <= '0;
      gain_factor <= GAIN_FACTOR_RESET;
    end else begin
      left_store  <= left_next;
      right_store <= right_next;
      if (ctrl.gain_we) begin
        gain_factor <= GAIN_FACTOR_W'(gain_data) * GAIN_FACTOR_W'(SCALE_RECIP);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/odometry_line_sensor_scanner.sv @@
// Odometry and line sensor scanner.
// Input channel (in_valid / in_stall): one item per converter sample, or a
// counter load when action is set. Samples walk the slots left wheel, right
// wheel, left line, right line; a load leaves the slot where it is.
// Output channel (out_valid / out_stall): exactly one result item per input
// item, in order, with the slot handled, edge flags, both wheel counts and the
// line sensor values and their difference.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver does not stall; the
// whole update for an item is one pass of compare, increment and one multiply
// between the two registers.
// When the receiver stalls, the result register holds; one more item waits in
// the input register, then in_stall rises until the result is taken.
// Configuration (cfg_valid / cfg_ready): cfg_ready is always high; the user
// must write only while the block is idle; the block does not enforce it. Reset
// (rst, synchronous) clears counters, marks, line stores and the slot, empties
// both registers and restores the default thresholds and gain.
`default_nettype none

module odometry_line_sensor_scanner #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // Input item channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 action,
  input  wire  [olss_pkg::SAMPLE_W-1:0]       sample,
  input  wire  signed [olss_pkg::LOAD_W-1:0]  load_left,
  input  wire  signed [olss_pkg::LOAD_W-1:0]  load_right,
  // Result item channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [1:0]                          handled_slot,
  output logic                                left_edge,
  output logic                                right_edge,
  output logic signed [olss_pkg::LOAD_W-1:0]  left_count,
  output logic signed [olss_pkg::LOAD_W-1:0]  right_count,
  output logic [olss_pkg::SAMPLE_W-1:0]       line_left_value,
  output logic [olss_pkg::SCALED_W-1:0]       line_right_scaled,
  output logic signed [olss_pkg::DIFF_W-1:0]  line_difference,
  // Configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [olss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [olss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import olss_pkg::*;

  // Configuration registers
  logic [THRESH_W-1:0] left_low;
  logic [THRESH_W-1:0] left_high;
  logic [THRESH_W-1:0] right_low;
  logic [THRESH_W-1:0] right_high;
  logic                cfg_we;
  logic                gain_we;

  // Input register
  logic                      iv;
  logic                      in_action;
  logic [SAMPLE_W-1:0]       in_sample;
  logic signed [LOAD_W-1:0]  in_load_left;
  logic signed [LOAD_W-1:0]  in_load_right;

  // Processing control
  slot_t       slot;
  logic        advance;
  logic        work;
  logic        is_load;
  logic        is_sample;
  wheel_ctrl_t left_ctrl;
  wheel_ctrl_t right_ctrl;
  line_ctrl_t  line_ctrl;

  // Unit results
  logic                   left_hit;
  logic                   right_hit;
  logic [COUNT_WIDTH-1:0] left_count_next;
  logic [COUNT_WIDTH-1:0] right_count_next;
  logic [SAMPLE_W-1:0]    line_left_next;
  logic [SCALED_W-1:0]    line_right_next;
  logic signed [DIFF_W-1:0] line_diff_next;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign gain_we   = cfg_we && (cfg_index == REG_RIGHT_GAIN);
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = iv && !advance;
  assign work      = iv && advance;
  assign is_load   = work && (in_action == ACTION_LOAD);
  assign is_sample = work && (in_action == ACTION_SAMPLE);

  // Steer the item to the unit of the current slot
  always_comb begin
    left_ctrl.step  = is_sample && (slot == SLOT_LEFT_WHEEL);
    left_ctrl.load  = is_load;
    right_ctrl.step = is_sample && (slot == SLOT_RIGHT_WHEEL);
    right_ctrl.load = is_load;
    line_ctrl.step_left  = is_sample && (slot == SLOT_LEFT_LINE);
    line_ctrl.step_right = is_sample && (slot == SLOT_RIGHT_LINE);
    line_ctrl.gain_we    = gain_we;
  end

  olss_wheel #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_left_wheel (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (left_ctrl),
    .sample         (in_sample),
    .low_threshold  (left_low),
    .high_threshold (left_high),
    .load_value     (COUNT_WIDTH'(in_load_left)),
    .edge_hit       (left_hit),
    .count_next     (left_count_next)
  );

  olss_wheel #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_right_wheel (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (right_ctrl),
    .sample         (in_sample),
    .low_threshold  (right_low),
    .high_threshold (right_high),
    .load_value     (COUNT_WIDTH'(in_load_right)),
    .edge_hit       (right_hit),
    .count_next     (right_count_next)
  );

  olss_line u_line (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (line_ctrl),
    .sample          (in_sample),
    .gain_data       (cfg_data[GAIN_W-1:0]),
    .left_next       (line_left_next),
    .right_next      (line_right_next),
    .difference_next (line_diff_next)
  );

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      left_low   <= LEFT_LOW_RESET;
      left_high  <= LEFT_HIGH_RESET;
      right_low  <= RIGHT_LOW_RESET;
      right_high <= RIGHT_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_LOW:   left_low   <= cfg_data[THRESH_W-1:0];
        REG_LEFT_HIGH:  left_high  <= cfg_data[THRESH_W-1:0];
        REG_RIGHT_LOW:  right_low  <= cfg_data[THRESH_W-1:0];
        REG_RIGHT_HIGH: right_high <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture an item into the input register; drain it as it is worked
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv <= 1'b1;
    end else if (advance) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_action     <= action;
      in_sample     <= sample;
      in_load_left  <= load_left;
      in_load_right <= load_right;
    end
  end

  // Advance the slot on every sample item
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_LEFT_WHEEL;
    end else if (is_sample) begin
      slot <= slot_t'(slot + 2'd1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      handled_slot      <= is_load ? SLOT_LEFT_WHEEL : slot;
      left_edge         <= left_hit;
      right_edge        <= right_hit;
      left_count        <= LOAD_W'(left_count_next);
      right_count       <= LOAD_W'(right_count_next);
      line_left_value   <= line_left_next;
      line_right_scaled <= line_right_next;
      line_difference   <= line_diff_next;
    end
  end

  // Stall toward the sender only when a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A sample item moves the slot on by one; a load leaves it
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    is_sample |=> (slot == slot_t'($past(slot) + 2'd1)))
    else $error("slot did not advance after a sample item");

  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    is_load |=> $stable(slot))
    else $error("slot changed on a load item");

  // Edge flags belong to their own wheel slot only
  a_left_edge_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && left_edge) |-> (handled_slot == SLOT_LEFT_WHEEL && !right_edge))
    else $error("left edge flagged outside the left wheel slot");

  a_right_edge_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && right_edge) |-> (handled_slot == SLOT_RIGHT_WHEEL))
    else $error("right edge flagged outside the right wheel slot");

endmodule

`default_nettype wire
